[rtl/core/jsu_pkg.sv]
// Package for the JSON string unescaper: parser phases, result kinds,
// character codes, the decode step record and the hex digit helper.
// No dependencies.
`timescale 1ns / 1ps

package jsu_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_STR  = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } phase_t;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_TAB = 8'h09;

    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF_CONT  = 8'h80;

    localparam logic [1:0] HEX_LAST = 2'd3;

    // Results caused by one input byte: up to three, all of one kind.
    typedef struct packed {
        logic [1:0]      count;
        logic [1:0]      kind;
        logic [2:0][7:0] bytes;
    } grp_t;

    // Full outcome of one decode step: the results and the new state.
    typedef struct packed {
        grp_t        grp;
        phase_t      phase;
        logic [1:0]  hex_cnt;
        logic [15:0] code_acc;
    } step_t;

    // Bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

[rtl/core/jsu_decode.sv]
// Combinational decode step of the JSON string unescaper: from the current
// parser state and one input byte it forms the results and the next state.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_decode (
    input  logic            [7:0]  in_byte,
    input  logic                   text_end,
    input  jsu_pkg::phase_t        phase,
    input  logic            [1:0]  hex_cnt,
    input  logic            [15:0] code_acc,
    output jsu_pkg::step_t         step
);
    import jsu_pkg::*;

    logic [4:0]  hv;
    logic [15:0] acc_new;

    assign hv      = hex_value(in_byte);
    assign acc_new = {code_acc[11:0], hv[3:0]};

    always_comb begin
        step            = '0;
        step.phase      = phase;
        step.hex_cnt    = hex_cnt;
        step.code_acc   = code_acc;
        step.grp.kind   = KIND_BYTE;

        if (text_end) begin
            step = '0;
            step.phase     = PH_IDLE;
            step.grp.count = 2'd1;
            step.grp.kind  = KIND_ERROR;
        end else begin
            case (phase)
                PH_IDLE: begin
                    if (in_byte == CH_QUOTE) begin
                        step.phase = PH_STR;
                    end else begin
                        step.grp.count = 2'd1;
                        step.grp.kind  = KIND_ERROR;
                    end
                end
                PH_STR: begin
                    if (in_byte == CH_QUOTE) begin
                        step.phase     = PH_IDLE;
                        step.grp.count = 2'd1;
                        step.grp.kind  = KIND_CLOSE;
                    end else if (in_byte == CH_BSLASH) begin
                        step.phase = PH_ESC;
                    end else begin
                        step.grp.count    = 2'd1;
                        step.grp.bytes[0] = in_byte;
                    end
                end
                PH_ESC: begin
                    step.phase     = PH_STR;
                    step.grp.count = 2'd1;
                    case (in_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: step.grp.bytes[0] = in_byte;
                        CH_B: step.grp.bytes[0] = CTL_BS;
                        CH_F: step.grp.bytes[0] = CTL_FF;
                        CH_N: step.grp.bytes[0] = CTL_LF;
                        CH_R: step.grp.bytes[0] = CTL_CR;
                        CH_T: step.grp.bytes[0] = CTL_TAB;
                        CH_U: begin
                            step.phase     = PH_HEX;
                            step.hex_cnt   = 2'd0;
                            step.code_acc  = 16'd0;
                            step.grp.count = 2'd0;
                        end
                        default: begin
                            step.phase     = PH_IDLE;
                            step.grp.kind  = KIND_ERROR;
                        end
                    endcase
                end
                default: begin
                    if (!hv[4]) begin
                        step.phase     = PH_IDLE;
                        step.hex_cnt   = 2'd0;
                        step.code_acc  = 16'd0;
                        step.grp.count = 2'd1;
                        step.grp.kind  = KIND_ERROR;
                    end else if (hex_cnt != HEX_LAST) begin
                        step.code_acc = acc_new;
                        step.hex_cnt  = hex_cnt + 2'd1;
                    end else begin
                        step.phase    = PH_STR;
                        step.hex_cnt  = 2'd0;
                        step.code_acc = 16'd0;
                        if (acc_new[15:7] == 9'd0) begin
                            step.grp.count    = 2'd1;
                            step.grp.bytes[0] = acc_new[7:0];
                        end else if (acc_new[15:11] == 5'd0) begin
                            step.grp.count    = 2'd2;
                            step.grp.bytes[0] = UTF_LEAD2 | {3'd0, acc_new[10:6]};
                            step.grp.bytes[1] = UTF_CONT | {2'd0, acc_new[5:0]};
                        end else begin
                            step.grp.count    = 2'd3;
                            step.grp.bytes[0] = UTF_LEAD3 | {4'd0, acc_new[15:12]};
                            step.grp.bytes[1] = UTF_CONT | {2'd0, acc_new[11:6]};
                            step.grp.bytes[2] = UTF_CONT | {2'd0, acc_new[5:0]};
                        end
                    end
                end
            endcase
        end
    end

endmodule

[rtl/core/jsu_burst.sv]
// Result register and serializer: holds the results of one decoded byte
// and presents them one transfer at a time on the result channel.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_burst (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  jsu_pkg::grp_t       grp,
    output logic                load_ok,
    output logic                m_valid,
    input  logic                m_ready,
    output logic          [7:0] m_out_byte,
    output logic          [1:0] m_kind,
    output logic                m_last
);
    import jsu_pkg::*;

    logic [2:0][7:0] bytes_reg;
    logic [1:0]      kind_reg;
    logic [1:0]      left_reg, left_next;
    logic [1:0]      idx_reg, idx_next;
    logic            take;

    assign m_valid    = (left_reg != 2'd0);
    assign take       = m_valid && m_ready;
    assign load_ok    = (left_reg == 2'd0) || (left_reg == 2'd1 && m_ready);
    assign m_kind     = kind_reg;
    assign m_last     = (left_reg == 2'd1);
    assign m_out_byte = bytes_reg[idx_reg];

    always_comb begin
        left_next = left_reg;
        idx_next  = idx_reg;
        if (load) begin
            left_next = grp.count;
            idx_next  = 2'd0;
        end else if (take) begin
            left_next = left_reg - 2'd1;
            idx_next  = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= 2'd0;
            idx_reg  <= 2'd0;
        end else begin
            left_reg <= left_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= grp.bytes;
            kind_reg  <= grp.kind;
        end
    end

endmodule

[rtl/core/json_string_unescape_utf8.sv]
// Top level of the streaming JSON string unescaper.
// Depends on jsu_pkg, jsu_decode and jsu_burst.
`timescale 1ns / 1ps

// The block takes the raw text of one JSON string literal one byte per
// transfer, starting at its opening quote, and returns the decoded bytes.
// Plain bytes pass through, the short escapes become their single bytes and
// a \uXXXX escape becomes one to three UTF-8 bytes (surrogates are encoded
// directly, unpaired). A closing quote gives one result of kind close, and a
// missing opening quote, a bad escape, a bad hex digit or end of text gives
// one result of kind error; both return the parser to idle. m_last marks the
// final result caused by one input transfer. An input byte is decoded in the
// cycle it is accepted and its results are available on the next cycle. The
// block takes one input byte per cycle as long as each byte causes at most
// one result and the result channel keeps up; a byte that causes more than
// one result holds the result register until the last of them has left, so
// after a two- or three-byte UTF-8 burst the next input waits until it is out.
// The input is taken in the same cycle the last result of a burst leaves.
module json_string_unescape_utf8 (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_text_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_kind,
    output logic       m_last
);
    import jsu_pkg::*;

    phase_t      phase_reg;
    logic [1:0]  hex_cnt_reg;
    logic [15:0] code_acc_reg;
    step_t       step;
    logic        load_ok;
    logic        accept;

    // The result register can take a new group when it is empty or when its
    // final result leaves in this same cycle.
    assign s_ready = load_ok;
    assign accept  = s_valid && s_ready;

    jsu_decode u_decode (
        .in_byte  (s_in_byte),
        .text_end (s_text_end),
        .phase    (phase_reg),
        .hex_cnt  (hex_cnt_reg),
        .code_acc (code_acc_reg),
        .step     (step)
    );

    jsu_burst u_burst (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .grp        (step.grp),
        .load_ok    (load_ok),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_kind     (m_kind),
        .m_last     (m_last)
    );

    // Parser state advances only on an accepted input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            hex_cnt_reg  <= 2'd0;
            code_acc_reg <= 16'd0;
        end else if (accept) begin
            phase_reg    <= step.phase;
            hex_cnt_reg  <= step.hex_cnt;
            code_acc_reg <= step.code_acc;
        end
    end

    // The hex digit count and the code accumulator only live inside a \u escape.
    a_hex_state_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_HEX) |-> (hex_cnt_reg == 2'd0 && code_acc_reg == 16'd0))
        else $error("hex state not cleared outside a unicode escape");

    // Close and error results stand alone and carry a zero byte.
    a_marker_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_BYTE) |-> (m_last && m_out_byte == 8'd0))
        else $error("close or error result is not a single zero result");

    // End of text always yields an error result on the next cycle.
    a_end_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_text_end) |=> (m_valid && m_kind == KIND_ERROR))
        else $error("end of text did not produce an error result");

    // A UTF-8 burst continues until its last byte has gone, and the input is
    // held off while more than its last byte is still waiting.
    a_burst_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (m_valid && (m_last || !s_ready)))
        else $error("result burst broken before its last byte");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for json_string_unescape_utf8: directed and random string literals.
// Depends on jsu_pkg and the unescaper RTL; holds its own decoder and scoreboard class.
`timescale 1ns / 1ps

import jsu_pkg::*;

typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
} decoded_t;

class unescape_scoreboard;
    phase_t      phase;
    logic [1:0]  hex_count;
    logic [15:0] code_acc;
    decoded_t    decoded_q[$];
    int          errors;
    int          seen;

    function new();
        errors = 0;
        seen = 0;
        clear_state();
    endfunction

    function void clear_state();
        phase = PH_IDLE;
        hex_count = 2'd0;
        code_acc = 16'd0;
    endfunction

    function void push(logic [7:0] d, logic [1:0] k, logic l);
        decoded_t r;
        r.data = d;
        r.kind = k;
        r.last = l;
        decoded_q.insert(decoded_q.size(), r);
    endfunction

    function void push_error();
        clear_state();
        push(8'h00, KIND_ERROR, 1'b1);
    endfunction

    // Bit 4 set when the byte is a hex digit of either case.
    function logic [4:0] hex_digit(logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= "0" && c <= "9") begin
            v = c - "0";
        end else if (c >= "a" && c <= "f") begin
            v = c - "a" + 8'd10;
        end else if (c >= "A" && c <= "F") begin
            v = c - "A" + 8'd10;
        end else begin
            return 5'd0;
        end
        return {1'b1, v[3:0]};
    endfunction

    // Code units are encoded as they stand; surrogates take three bytes.
    function void push_utf8(logic [15:0] code);
        if (code < 16'h0080) begin
            push(code[7:0], KIND_BYTE, 1'b1);
        end else if (code < 16'h0800) begin
            push(UTF_LEAD2 | {3'b000, code[10:6]}, KIND_BYTE, 1'b0);
            push(UTF_CONT | {2'b00, code[5:0]}, KIND_BYTE, 1'b1);
        end else begin
            push(UTF_LEAD3 | {4'h0, code[15:12]}, KIND_BYTE, 1'b0);
            push(UTF_CONT | {2'b00, code[11:6]}, KIND_BYTE, 1'b0);
            push(UTF_CONT | {2'b00, code[5:0]}, KIND_BYTE, 1'b1);
        end
    endfunction

    // Called once per accepted input transfer; queues the results it causes.
    function void note_input(logic [7:0] c, logic text_end);
        logic [4:0]  digit;
        logic [7:0]  mapped;
        logic [15:0] code;
        if (text_end) begin
            push_error();
            return;
        end
        case (phase)
            PH_IDLE: begin
                if (c == CH_QUOTE) phase = PH_STR;
                else push_error();
            end
            PH_STR: begin
                if (c == CH_QUOTE) begin
                    clear_state();
                    push(8'h00, KIND_CLOSE, 1'b1);
                end else if (c == CH_BSLASH) begin
                    phase = PH_ESC;
                end else begin
                    push(c, KIND_BYTE, 1'b1);
                end
            end
            PH_ESC: begin
                mapped = c;
                case (c)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: mapped = c;
                    CH_B: mapped = CTL_BS;
                    CH_F: mapped = CTL_FF;
                    CH_N: mapped = CTL_LF;
                    CH_R: mapped = CTL_CR;
                    CH_T: mapped = CTL_TAB;
                    CH_U: begin
                        phase = PH_HEX;
                        hex_count = 2'd0;
                        code_acc = 16'd0;
                        return;
                    end
                    default: begin
                        push_error();
                        return;
                    end
                endcase
                phase = PH_STR;
                push(mapped, KIND_BYTE, 1'b1);
            end
            default: begin
                digit = hex_digit(c);
                if (!digit[4]) begin
                    push_error();
                end else begin
                    code_acc = {code_acc[11:0], digit[3:0]};
                    if (hex_count != HEX_LAST) begin
                        hex_count = hex_count + 2'd1;
                    end else begin
                        code = code_acc;
                        phase = PH_STR;
                        hex_count = 2'd0;
                        code_acc = 16'd0;
                        push_utf8(code);
                    end
                end
            end
        endcase
    endfunction

    task report(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task check_result(logic [7:0] d, logic [1:0] k, logic l);
        decoded_t want;
        seen++;
        if (decoded_q.size() == 0) begin
            report($sformatf("result %0d (byte %h kind %0d) with nothing pending", seen, d, k));
            return;
        end
        want = decoded_q.pop_front();
        if (k !== want.kind)
            report($sformatf("result %0d kind %0d, want %0d", seen, k, want.kind));
        if (d !== want.data)
            report($sformatf("result %0d out_byte %h, want %h", seen, d, want.data));
        if (l !== want.last)
            report($sformatf("result %0d last %b, want %b", seen, l, want.last));
    endtask
endclass

module tb_top;

    // Idle cycles the receiver holds off for to fill the block and stall its input.
    localparam int LONG_HOLD = 60;
    localparam int ITEM_TARGET = 200;

    typedef struct packed {
        logic [7:0] data;
        logic       text_end;
    } text_item_t;

    // Every input of the block starts at a known value.
    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       s_text_end = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic [1:0] m_kind;
    logic       m_last;

    text_item_t text_q[$];
    int         items_sent = 0;
    bit         quiet = 1'b0;
    bit         hold_req = 1'b0;

    unescape_scoreboard sb = new();

    json_string_unescape_utf8 DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_text_end (s_text_end),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_kind     (m_kind),
        .m_last     (m_last)
    );

    always #10 aclk = ~aclk;

    // Text assembly. Each literal is built as a list of input transfers and then sent.
    function void add(logic [7:0] b, logic e);
        text_item_t t;
        t.data = b;
        t.text_end = e;
        text_q.insert(text_q.size(), t);
    endfunction

    // Hex digits above nine come out in a random case.
    function logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10) return "0" + v;
        return ($urandom_range(0, 1) ? "a" : "A") + v - 4'd10;
    endfunction

    function void add_hex(logic [15:0] code);
        add(hex_char(code[15:12]), 1'b0);
        add(hex_char(code[11:8]), 1'b0);
        add(hex_char(code[7:4]), 1'b0);
        add(hex_char(code[3:0]), 1'b0);
    endfunction

    // Any byte that stays plain inside a string, with the extremes favored.
    function logic [7:0] plain_byte();
        logic [7:0] b;
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        b = 8'($urandom_range(0, 255));
        while (b == CH_QUOTE || b == CH_BSLASH) b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Code units spread over the one-, two- and three-byte ranges and their edges.
    function logic [15:0] pick_code();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 16'hFFFF));
            1: return 16'($urandom_range(0, 16'h007F));
            2: return 16'($urandom_range(16'h0080, 16'h07FF));
            default: begin
                case ($urandom_range(0, 7))
                    0: return 16'h0000;
                    1: return 16'h007F;
                    2: return 16'h0080;
                    3: return 16'h07FF;
                    4: return 16'h0800;
                    5: return 16'hD800;
                    6: return 16'hDFFF;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    function void add_element();
        case ($urandom_range(0, 5))
            0, 1, 2: add(plain_byte(), 1'b0);
            3: begin
                add(CH_BSLASH, 1'b0);
                case ($urandom_range(0, 7))
                    0: add(CH_QUOTE, 1'b0);
                    1: add(CH_BSLASH, 1'b0);
                    2: add(CH_SLASH, 1'b0);
                    3: add(CH_B, 1'b0);
                    4: add(CH_F, 1'b0);
                    5: add(CH_N, 1'b0);
                    6: add(CH_R, 1'b0);
                    default: add(CH_T, 1'b0);
                endcase
            end
            default: begin
                add(CH_BSLASH, 1'b0);
                add(CH_U, 1'b0);
                add_hex(pick_code());
            end
        endcase
    endfunction

    // Ends a literal early: end of text, a bad escape or a bad hex digit.
    function void add_break();
        logic [7:0] b;
        int         ndig;
        case ($urandom_range(0, 2))
            0: begin
                // End of text can land right inside the string, after a backslash
                // or part way through the hex digits.
                case ($urandom_range(0, 2))
                    1: add(CH_BSLASH, 1'b0);
                    2: begin
                        add(CH_BSLASH, 1'b0);
                        add(CH_U, 1'b0);
                        ndig = $urandom_range(0, 3);
                        for (int i = 0; i < ndig; i++)
                            add(hex_char(4'($urandom_range(0, 15))), 1'b0);
                    end
                    default: ;
                endcase
                add(8'($urandom_range(0, 255)), 1'b1);
            end
            1: begin
                add(CH_BSLASH, 1'b0);
                b = 8'($urandom_range(0, 255));
                while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_B ||
                       b == CH_F || b == CH_N || b == CH_R || b == CH_T || b == CH_U)
                    b = 8'($urandom_range(0, 255));
                add(b, 1'b0);
            end
            default: begin
                add(CH_BSLASH, 1'b0);
                add(CH_U, 1'b0);
                ndig = $urandom_range(0, 3);
                for (int i = 0; i < ndig; i++)
                    add(hex_char(4'($urandom_range(0, 15))), 1'b0);
                b = 8'($urandom_range(0, 255));
                while (sb.hex_digit(b) != 5'd0) b = 8'($urandom_range(0, 255));
                add(b, 1'b0);
            end
        endcase
    endfunction

    // Mostly well-formed literals with random content; some broken ones and some
    // noise in idle (a missing opening quote or end of text before any string).
    function void build_literal();
        int  n;
        int  brk_at;
        bit  broken;
        int  nnoise;
        if ($urandom_range(0, 9) == 0) begin
            nnoise = $urandom_range(1, 3);
            for (int i = 0; i < nnoise; i++) begin
                if ($urandom_range(0, 1)) begin
                    add(8'($urandom_range(0, 255)), 1'b1);
                end else begin
                    add(plain_byte(), 1'b0);
                end
            end
        end
        broken = ($urandom_range(0, 5) == 0);
        n = $urandom_range(0, 8);
        brk_at = $urandom_range(0, n);
        add(CH_QUOTE, 1'b0);
        for (int i = 0; i < n; i++) begin
            if (broken && i == brk_at) begin
                add_break();
                return;
            end
            add_element();
        end
        if (broken) begin
            add_break();
            return;
        end
        add(CH_QUOTE, 1'b0);
    endfunction

    // Directed opening: errors in idle, the extremes of a plain byte, a short
    // escape, the largest and the zero code unit, a bad escape, a bad hex digit,
    // end of text inside a string and an empty string.
    function void build_directed();
        add("x", 1'b0);
        add(8'($urandom_range(0, 255)), 1'b1);
        add(CH_QUOTE, 1'b0);
        add(8'h00, 1'b0);
        add(8'hFF, 1'b0);
        add(CH_BSLASH, 1'b0);
        add(CH_N, 1'b0);
        add(CH_BSLASH, 1'b0);
        add(CH_U, 1'b0);
        add("F", 1'b0);
        add("f", 1'b0);
        add("F", 1'b0);
        add("f", 1'b0);
        add(CH_BSLASH, 1'b0);
        add(CH_U, 1'b0);
        add_hex(16'h0000);
        add(CH_BSLASH, 1'b0);
        add("q", 1'b0);
        add(CH_QUOTE, 1'b0);
        add(CH_BSLASH, 1'b0);
        add(CH_U, 1'b0);
        add("g", 1'b0);
        add(CH_QUOTE, 1'b0);
        add(8'($urandom_range(0, 255)), 1'b1);
        add(CH_QUOTE, 1'b0);
        add(CH_QUOTE, 1'b0);
    endfunction

    // Drains the text queue onto the input channel. Valid rises only after any
    // idle gap and then stays high until the transfer happens at an edge where
    // ready is high; the accepted item is handed to the scoreboard at that edge.
    task send_text();
        text_item_t t;
        while (text_q.size() != 0) begin
            t = text_q.pop_front();
            if (!quiet && $urandom_range(0, 4) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            s_valid    <= 1'b1;
            s_in_byte  <= t.data;
            s_text_end <= t.text_end;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            sb.note_input(t.data, t.text_end);
            items_sent++;
        end
    endtask

    task wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.decoded_q.size() != 0) @(posedge aclk);
    endtask

    // Result channel receiver. Ready idles in random bursts, holds off for a long
    // stretch once on request, and stays high in the quiet part at the end.
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // Every result transfer is checked against the oldest pending prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_out_byte, m_kind, m_last);
        end
    end

    // Main sequence: reset, the directed part, then random literals with a long
    // receiver hold, a full drain in the middle and a quiet stretch at the end.
    initial begin
        bit hold_done;
        bit paused;
        hold_done = 1'b0;
        paused = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        build_directed();
        send_text();
        while (items_sent < ITEM_TARGET) begin
            if (!hold_done && items_sent >= 70) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!paused && items_sent >= 120) begin
                wait_drained();
                paused = 1'b1;
            end
            if (!quiet && items_sent >= 160) begin
                wait_drained();
                quiet = 1'b1;
            end
            build_literal();
            send_text();
        end
        wait_drained();
        // The block's results are registered; the extra wait catches any strays.
        repeat (8) @(posedge aclk);
        if (sb.decoded_q.size() != 0) begin
            sb.report($sformatf("%0d predicted results never arrived", sb.decoded_q.size()));
        end
        if (sb.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/jsu_pkg.sv
rtl/core/jsu_decode.sv
rtl/core/jsu_burst.sv
rtl/core/json_string_unescape_utf8.sv
tb/tb_top.sv
